// ===== design/wgs_pkg.sv =====
// Shared types, widths and helpers for the weighted gradient score block.
// No dependencies; imported by every module of the block.
package wgs_pkg;

  localparam int unsigned DATA_W   = 16;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned SUM_W    = 50;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned ROWLEN_W = 9;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam int unsigned MAX_COLS_DEF   = 256;
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = 9'd64;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 8'd200;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_WORST = 1'b1;

  typedef struct packed {
    logic [SUM_W-1:0] diff;
    logic [SUM_W-1:0] maxv;
  } sums_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// ===== design/wgs_front.sv =====
// Point front end: line store, gradients, weighted products and grid sums.
// Depends on wgs_pkg; pushes finished grid sums into wgs_fifo.
module wgs_front #(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [wgs_pkg::ROWLEN_W-1:0]      row_length_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [wgs_pkg::DATA_W-1:0] ref_sample_i,
  input  logic signed [wgs_pkg::DATA_W-1:0] eval_sample_i,
  input  logic [wgs_pkg::WGT_W-1:0]         col_weight_i,
  input  logic [wgs_pkg::WGT_W-1:0]         row_weight_i,
  input  logic                              last_point_i,
  input  logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_cnt_i,
  output logic                              push_o,
  output wgs_pkg::sums_t                    push_data_o
);
  import wgs_pkg::*;

  localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned LW    = (COL_W + 1 > ROWLEN_W) ? COL_W + 1 : ROWLEN_W;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PW    = $clog2(FIFO_DEPTH + 4);

  function automatic logic [DATA_W-1:0] mag17(input logic signed [DATA_W:0] v);
    logic signed [DATA_W:0] a;
    a = (v < 0) ? -v : v;
    return a[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W:0] mag18(input logic signed [DATA_W+1:0] v);
    logic signed [DATA_W+1:0] a;
    a = (v < 0) ? -v : v;
    return a[DATA_W:0];
  endfunction

  logic accept;
  logic [PW-1:0] pending;

  logic [COL_W-1:0] col_q, col_d;
  logic             first_row_q, first_row_d;
  logic signed [DATA_W-1:0] left_ref_q, left_eval_q;
  logic [2*DATA_W-1:0] line_mem [MAX_COLS];
  logic [2*DATA_W-1:0] line_rd_q;

  logic [LW-1:0] len_eff, col_next;

  // stage A
  logic a_vld_q, a_last_q;
  logic signed [DATA_W-1:0] a_ref_q, a_eval_q, a_lref_q, a_leval_q;
  logic [WGT_W-1:0] a_wc_q, a_wr_q;
  // stage B
  logic b_vld_q, b_last_q;
  logic [DATA_W:0]   b_dc_q, b_dr_q;
  logic [DATA_W-1:0] b_mc_q, b_mr_q;
  logic [WGT_W-1:0]  b_wc_q, b_wr_q;
  // stage C
  logic c_vld_q, c_last_q;
  logic [DATA_W+WGT_W:0]   c_pdc_q, c_pdr_q;
  logic [DATA_W+WGT_W-1:0] c_pmc_q, c_pmr_q;
  // sums
  logic [SUM_W-1:0] diff_q, max_q, diff_new, max_new;

  logic signed [DATA_W:0]   gr_c, ge_c, gr_r, ge_r;
  logic signed [DATA_W-1:0] above_ref, above_eval;

  // room in the queue for every grid end still in flight
  assign pending    = PW'(fifo_cnt_i) + PW'(a_vld_q & a_last_q) + PW'(b_vld_q & b_last_q)
                    + PW'(c_vld_q & c_last_q);
  assign in_ready_o = (pending < PW'(FIFO_DEPTH));
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    len_eff = LW'(row_length_i);
    if (len_eff < LW'(2)) begin
      len_eff = LW'(2);
    end else if (len_eff > LW'(MAX_COLS)) begin
      len_eff = LW'(MAX_COLS);
    end
    col_next    = LW'(col_q) + LW'(1);
    col_d       = col_q;
    first_row_d = first_row_q;
    if (last_point_i) begin
      col_d       = '0;
      first_row_d = 1'b1;
    end else if (col_next >= len_eff) begin
      col_d       = '0;
      first_row_d = 1'b0;
    end else begin
      col_d       = col_next[COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      first_row_q <= 1'b1;
      left_ref_q  <= '0;
      left_eval_q <= '0;
    end else if (accept) begin
      col_q       <= col_d;
      first_row_q <= first_row_d;
      left_ref_q  <= ref_sample_i;
      left_eval_q <= eval_sample_i;
    end
  end

  // read-before-write line store
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_rd_q       <= line_mem[col_q];
      line_mem[col_q] <= {ref_sample_i, eval_sample_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      a_last_q <= 1'b0;
      b_vld_q  <= 1'b0;
      b_last_q <= 1'b0;
      c_vld_q  <= 1'b0;
      c_last_q <= 1'b0;
    end else begin
      a_vld_q  <= accept;
      a_last_q <= last_point_i;
      b_vld_q  <= a_vld_q;
      b_last_q <= a_last_q;
      c_vld_q  <= b_vld_q;
      c_last_q <= b_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ref_q   <= ref_sample_i;
      a_eval_q  <= eval_sample_i;
      a_lref_q  <= left_ref_q;
      a_leval_q <= left_eval_q;
      a_wc_q    <= (col_q != '0) ? col_weight_i : '0;
      a_wr_q    <= first_row_q ? '0 : row_weight_i;
    end
  end

  assign above_ref  = line_rd_q[2*DATA_W-1:DATA_W];
  assign above_eval = line_rd_q[DATA_W-1:0];

  always_comb begin
    gr_c = (DATA_W+1)'(a_ref_q)  - (DATA_W+1)'(a_lref_q);
    ge_c = (DATA_W+1)'(a_eval_q) - (DATA_W+1)'(a_leval_q);
    gr_r = (DATA_W+1)'(a_ref_q)  - (DATA_W+1)'(above_ref);
    ge_r = (DATA_W+1)'(a_eval_q) - (DATA_W+1)'(above_eval);
  end

  // the line store is unset in the first row after reset; a zero weight masks it
  always_ff @(posedge clk_i) begin
    b_dc_q <= mag18((DATA_W+2)'(gr_c) - (DATA_W+2)'(ge_c));
    b_dr_q <= (a_wr_q != '0) ? mag18((DATA_W+2)'(gr_r) - (DATA_W+2)'(ge_r)) : '0;
    b_mc_q <= (mag17(gr_c) > mag17(ge_c)) ? mag17(gr_c) : mag17(ge_c);
    b_mr_q <= (a_wr_q == '0) ? '0 :
              (mag17(gr_r) > mag17(ge_r)) ? mag17(gr_r) : mag17(ge_r);
    b_wc_q <= a_wc_q;
    b_wr_q <= a_wr_q;
  end

  always_ff @(posedge clk_i) begin
    c_pdc_q <= b_wc_q * b_dc_q;
    c_pdr_q <= b_wr_q * b_dr_q;
    c_pmc_q <= b_wc_q * b_mc_q;
    c_pmr_q <= b_wr_q * b_mr_q;
  end

  always_comb begin
    diff_new = sat_add(diff_q, SUM_W'({1'b0, c_pdc_q} + {1'b0, c_pdr_q}));
    max_new  = sat_add(max_q,  SUM_W'({1'b0, c_pmc_q} + {1'b0, c_pmr_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
      max_q  <= '0;
    end else if (c_vld_q) begin
      diff_q <= c_last_q ? '0 : diff_new;
      max_q  <= c_last_q ? '0 : max_new;
    end
  end

  assign push_o           = c_vld_q & c_last_q;
  assign push_data_o.diff = diff_new;
  assign push_data_o.maxv = max_new;

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (fifo_cnt_i < CNT_W'(FIFO_DEPTH)))
    else $error("grid sums pushed into a full queue");
  a_wrap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (LW'(col_q) < len_eff))
    else $error("column index beyond row length");
`endif

endmodule

// ===== design/wgs_fifo.sv =====
// Short queue of finished grid sums between the front end and the divider.
// Depends on wgs_pkg for the entry type.
module wgs_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  wgs_pkg::sums_t               push_data_i,
  input  logic                         pop_i,
  output logic                         not_empty_o,
  output wgs_pkg::sums_t               head_o,
  output logic [$clog2(DEPTH+1)-1:0]   cnt_o
);
  import wgs_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sums_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign do_pop      = pop_i & (cnt_q != '0);
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];
  assign cnt_o       = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty queue");
`endif

endmodule

// ===== design/wgs_div.sv =====
// Back end: scales the diff sum by 100 in Q8.8 and divides it by the max sum
// bit by bit, rounds, saturates and holds the result. Depends on wgs_pkg.
module wgs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wgs_pkg::SCALE_W-1:0]   scale_worst_i,
  input  logic                          not_empty_i,
  input  wgs_pkg::sums_t                head_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wgs_pkg::SCORE_W-1:0]   score_o,
  output logic                          degenerate_o
);
  import wgs_pkg::*;

  localparam int unsigned T_W   = SUM_W + 7;
  localparam int unsigned CNT_W = $clog2(SCORE_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state_q;
  logic [SUM_W-1:0]   num_q, den_q, rem_q;
  logic [T_W-1:0]     t_q;
  logic [SCORE_W-1:0] nlow_q, quo_q, score_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               degen_q;
  logic [SUM_W:0]     rem2, rem2_sub;

  assign pop_o        = (state_q == ST_IDLE) & not_empty_i;
  assign out_valid_o  = (state_q == ST_OUT);
  assign score_o      = score_q;
  assign degenerate_o = degen_q;

  assign rem2     = {rem_q, nlow_q[SCORE_W-1]};
  assign rem2_sub = rem2 - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: if (not_empty_i) state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_CHK;
        ST_CHK: begin
          if (den_q == '0 || {1'b0, t_q} >= {den_q, 8'b0}) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV:  if (cnt_q == '0) state_q <= ST_RND;
        ST_RND:  state_q <= ST_OUT;
        ST_OUT:  if (out_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // x100 as x64 + x32 + x4, then x256 by position
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        num_q <= head_i.diff;
        den_q <= head_i.maxv;
        t_q   <= {1'b0, head_i.diff, 6'b0} + {2'b0, head_i.diff, 5'b0};
      end
      ST_MUL: t_q <= t_q + {5'b0, num_q, 2'b0};
      ST_CHK: begin
        rem_q  <= SUM_W'(t_q[T_W-1:8]);
        nlow_q <= {t_q[7:0], 8'b0};
        quo_q  <= '0;
        cnt_q  <= CNT_W'(SCORE_W - 1);
        if (den_q == '0) begin
          score_q <= {scale_worst_i, 8'b0};
          degen_q <= 1'b1;
        end else begin
          score_q <= {SCORE_W{1'b1}};
          degen_q <= 1'b0;
        end
      end
      ST_DIV: begin
        if (!rem2_sub[SUM_W] || rem2[SUM_W]) begin
          rem_q <= rem2_sub[SUM_W-1:0];
          quo_q <= {quo_q[SCORE_W-2:0], 1'b1};
        end else begin
          rem_q <= rem2[SUM_W-1:0];
          quo_q <= {quo_q[SCORE_W-2:0], 1'b0};
        end
        nlow_q <= {nlow_q[SCORE_W-2:0], 1'b0};
        cnt_q  <= cnt_q - CNT_W'(1);
      end
      ST_RND: begin
        if ({rem_q, 1'b0} >= {1'b0, den_q} && quo_q != {SCORE_W{1'b1}}) begin
          score_q <= quo_q + SCORE_W'(1);
        end else begin
          score_q <= quo_q;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (den_q != '0))
    else $error("division entered with zero divisor");
  a_degen_q88: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (score_o[7:0] == 8'd0))
    else $error("degenerate score has a fraction");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RND) |-> (rem_q < den_q))
    else $error("remainder not below divisor");
`endif

endmodule

// ===== design/weighted_gradient_score.sv =====
// Top level of the weighted gradient score block: configuration registers,
// front end, sum queue and divider. Depends on wgs_pkg, wgs_front, wgs_fifo, wgs_div.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------------
//   in       | in_valid_i / in_ready_o   | ref/eval sample, col/row weight, last point
//   out      | out_valid_o / out_ready_i | score (Q8.8), degenerate
//   cfg      | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// One grid point per cycle while in_ready_o is high; the front end runs four register
// stages to the sums. A grid end enters the sum queue; the divider takes one grid at a
// time: two scale steps, one check, 16 quotient bits, one rounding step, then an output
// state held until taken; a saturated or zero-divisor grid skips division and rounding.
// in_ready_o drops only while the queue has no room for grid ends in flight.
// Reset needs no clearing pass; the line store holds no data until written.
module weighted_gradient_score #(
  parameter int unsigned MAX_COLS   = wgs_pkg::MAX_COLS_DEF,
  parameter int unsigned FIFO_DEPTH = wgs_pkg::FIFO_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wgs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wgs_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [wgs_pkg::DATA_W-1:0] ref_sample_i,
  input  logic signed [wgs_pkg::DATA_W-1:0] eval_sample_i,
  input  logic [wgs_pkg::WGT_W-1:0]         col_weight_i,
  input  logic [wgs_pkg::WGT_W-1:0]         row_weight_i,
  input  logic                              last_point_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [wgs_pkg::SCORE_W-1:0]       score_o,
  output logic                              degenerate_o
);
  import wgs_pkg::*;

  logic [ROWLEN_W-1:0] row_length_q;
  logic [SCALE_W-1:0]  scale_worst_q;

  logic                            push, pop, not_empty;
  sums_t                           push_data, head;
  logic [$clog2(FIFO_DEPTH+1)-1:0] fifo_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= ROWLEN_RESET;
      scale_worst_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROW_LENGTH:  row_length_q  <= cfg_data_i[ROWLEN_W-1:0];
        REG_SCALE_WORST: scale_worst_q <= cfg_data_i[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  wgs_front #(
    .MAX_COLS   (MAX_COLS),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_length_i  (row_length_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .ref_sample_i  (ref_sample_i),
    .eval_sample_i (eval_sample_i),
    .col_weight_i  (col_weight_i),
    .row_weight_i  (row_weight_i),
    .last_point_i  (last_point_i),
    .fifo_cnt_i    (fifo_cnt),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  wgs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head),
    .cnt_o       (fifo_cnt)
  );

  wgs_div u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .scale_worst_i (scale_worst_q),
    .not_empty_i   (not_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .score_o       (score_o),
    .degenerate_o  (degenerate_o)
  );

endmodule
